// ===== rtl/particle_slice_stream_decoder_core_defines.svh =====
// Assertion macros shared by the particle slice decoder RTL.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef PARTICLE_SLICE_STREAM_DECODER_CORE_DEFINES_SVH
`define PARTICLE_SLICE_STREAM_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psd assertion failed");
// Next-cycle implication, disabled while reset is high.
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psd assertion failed");
`else
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/psd_pkg.sv =====
// Types, constants and slice bookkeeping functions for the particle slice decoder.
// No dependencies; imported by particle_slice_stream_decoder_core.
`default_nettype none
package psd_pkg;

  localparam int OUT_W = 96;

  localparam logic [15:0] SKIP_WORD   = 16'hcaaa;
  localparam logic [15:0] MARKER_WORD = 16'h4000;
  localparam logic [8:0]  MARKER_ADD  = 9'd128;
  localparam logic [7:0]  UPPER_RESET = 8'd40;
  localparam logic [8:0]  LOWER_RESET = 9'd215;

  localparam logic REG_UPPER_LIMIT = 1'b0;
  localparam logic REG_LOWER_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    MODE_SCAN = 2'd0,
    MODE_HELD = 2'd1,
    MODE_PART = 2'd2
  } mode_t;

  typedef struct packed {
    logic        slice_open;
    logic        after_marker;
    logic [8:0]  shaded;
    logic [8:0]  unshaded;
    logic [10:0] width;
    logic [8:0]  height;
    logic [19:0] area;
    logic [10:0] upper;
    logic [10:0] lower;
    logic [1:0]  flags;   // bit 1 upper edge, bit 0 lower edge
  } part_t;

  // Field order matches the output tdata packing, last field first.
  typedef struct packed {
    logic        lower_flag;
    logic        upper_flag;
    logic [10:0] lower_touches;
    logic [10:0] upper_touches;
    logic [19:0] shaded_area;
    logic [8:0]  height_max;
    logic [10:0] width_slices;
    logic [27:0] time_word;
  } result_t;

  localparam part_t PART_CLEAR = '0;

  function automatic logic [10:0] sat_inc11(input logic [10:0] x);
    return (x == '1) ? x : x + 11'd1;
  endfunction

  // Fold the open slice into the particle statistics.
  function automatic part_t close_slice(input part_t p, input logic [7:0] upper_limit,
                                        input logic [8:0] lower_limit);
    part_t       r;
    logic [9:0]  depth;
    logic [20:0] area_sum;
    r = p;
    if (p.slice_open) begin
      depth = {1'b0, p.shaded} + {1'b0, p.unshaded};
      area_sum = {1'b0, p.area} + {12'b0, p.shaded};
      if (p.unshaded <= {1'b0, upper_limit}) begin
        r.upper = sat_inc11(p.upper);
        r.flags[1] = 1'b1;
      end
      if (depth >= {1'b0, lower_limit}) begin
        r.lower = sat_inc11(p.lower);
        r.flags[0] = 1'b1;
      end
      r.area = area_sum[20] ? '1 : area_sum[19:0];
      if (p.shaded > p.height) begin
        r.height = p.shaded;
      end
      r.slice_open = 1'b0;
      r.after_marker = 1'b0;
      r.shaded = '0;
      r.unshaded = '0;
    end
    return r;
  endfunction

  function automatic part_t start_slice(input part_t p, input logic [15:0] w);
    part_t r;
    r = p;
    r.width = sat_inc11(p.width);
    r.slice_open = 1'b1;
    if (w == MARKER_WORD) begin
      r.after_marker = 1'b1;
      r.shaded = '0;
      r.unshaded = MARKER_ADD;
    end else begin
      r.shaded = {2'b0, w[13:7]};
      r.unshaded = {2'b0, w[6:0]};
    end
    return r;
  endfunction

  function automatic result_t make_result(input logic [27:0] t, input part_t p);
    result_t r;
    r.time_word = t;
    r.width_slices = p.width;
    r.height_max = p.height;
    r.shaded_area = p.area;
    r.upper_touches = p.upper;
    r.lower_touches = p.lower;
    r.upper_flag = p.flags[1];
    r.lower_flag = p.flags[0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/particle_slice_stream_decoder_core.sv =====
// Particle slice stream decoder: parses probe words into per-particle statistics.
// Results are registered (output or skid register) as the word closing each is accepted.
// Throughput: one word per cycle unless the skid register is full, with one registered
// parse pass per word. A two-entry output stage (output register plus skid register) lets
// input continue while one result waits. Reset (rst, synchronous, active high) restores
// scan state and the default edge limits; depends on psd_pkg and the defines header.
`default_nettype none
`include "particle_slice_stream_decoder_core_defines.svh"

module particle_slice_stream_decoder_core
  import psd_pkg::*;
#(
  parameter int RECORD_WORDS = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [8:0]        cfg_data,
  // Input stream.
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [15:0]       s_tdata,   // [15:0] probe_word
  input  wire logic              s_tlast,   // record_last
  // Result stream.
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata    // [27:0] time_word, [38:28] width_slices,
                                            // [47:39] height_max, [67:48] shaded_area,
                                            // [78:68] upper_touches, [89:79] lower_touches,
                                            // [90] upper_flag, [91] lower_flag, rest zero
);

  // The word counter must hold RECORD_WORDS - 1, its largest value.
  localparam int CW = $clog2(RECORD_WORDS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(RECORD_WORDS - 1);

  // Edge limits written through the configuration port.
  logic [7:0] upper_limit;
  logic [8:0] lower_limit;

  // Parser state.
  mode_t         mode, mode_next;
  logic          at_record_start, at_record_start_next;
  logic          skip_record, skip_record_next;
  logic [15:0]   held_word, held_word_next;
  logic [27:0]   particle_time, particle_time_next;
  part_t         part, part_next;
  logic [CW-1:0] word_count, word_count_next;

  // Output stage.
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;

  logic    accept;
  logic    emit;
  result_t emit_data;
  logic    skip_now;
  logic    last;
  logic [9:0] cont_sum;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_RESET;
      lower_limit <= LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER_LIMIT: upper_limit <= cfg_data[7:0];
        REG_LOWER_LIMIT: lower_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // One pass over the incoming word. A word that starts a slice at the record end
  // closes two slices in this pass: the one it ends and the one it starts.
  always_comb begin
    mode_next = mode;
    at_record_start_next = at_record_start;
    skip_record_next = skip_record;
    held_word_next = held_word;
    particle_time_next = particle_time;
    part_next = part;
    word_count_next = word_count;
    emit = 1'b0;
    emit_data = make_result(particle_time, part);
    cont_sum = {1'b0, part.shaded} + {3'b0, s_tdata[13:7]} + {3'b0, s_tdata[6:0]};

    // A record that opens with the skip word is ignored as a whole.
    skip_now = skip_record || (at_record_start && (s_tdata == SKIP_WORD));

    if (!skip_now) begin
      case (mode)
        MODE_HELD: begin
          if (s_tdata[15]) begin
            particle_time_next = {held_word[13:0], s_tdata[13:0]};
            part_next = PART_CLEAR;
            mode_next = MODE_PART;
          end else begin
            mode_next = MODE_SCAN;
          end
        end
        MODE_PART: begin
          if (part.after_marker) begin
            // The word after a marker is always slice data, whatever its top bits.
            part_next.after_marker = 1'b0;
            part_next.shaded = {2'b0, s_tdata[13:7]};
            part_next.unshaded = MARKER_ADD + {2'b0, s_tdata[6:0]};
          end else if (s_tdata[15]) begin
            // A timing word closes the particle and may open the next one.
            part_next = close_slice(part, upper_limit, lower_limit);
            emit = 1'b1;
            emit_data = make_result(particle_time, part_next);
            held_word_next = s_tdata;
            mode_next = MODE_HELD;
          end else if (part.slice_open && (s_tdata[15:14] == 2'b00)) begin
            part_next.shaded = cont_sum[9] ? '1 : cont_sum[8:0];
          end else begin
            part_next = start_slice(close_slice(part, upper_limit, lower_limit), s_tdata);
          end
        end
        default: begin
          // Scan mode, and the unused mode code as well.
          if (s_tdata[15]) begin
            held_word_next = s_tdata;
            mode_next = MODE_HELD;
          end else begin
            mode_next = MODE_SCAN;
          end
        end
      endcase
    end

    // The record ends on the tlast mark or when the word count reaches its limit.
    last = s_tlast || (word_count >= LAST_CNT);
    if (last) begin
      if (!skip_now && (mode_next == MODE_PART)) begin
        emit = 1'b1;
        emit_data = make_result(particle_time_next,
                                close_slice(part_next, upper_limit, lower_limit));
      end
      mode_next = MODE_SCAN;
      part_next = PART_CLEAR;
      at_record_start_next = 1'b1;
      skip_record_next = 1'b0;
      word_count_next = '0;
    end else begin
      at_record_start_next = 1'b0;
      skip_record_next = skip_now;
      word_count_next = word_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SCAN;
      at_record_start <= 1'b1;
      skip_record <= 1'b0;
      held_word <= '0;
      particle_time <= '0;
      part <= PART_CLEAR;
      word_count <= '0;
    end else if (accept) begin
      mode <= mode_next;
      at_record_start <= at_record_start_next;
      skip_record <= skip_record_next;
      held_word <= held_word_next;
      particle_time <= particle_time_next;
      part <= part_next;
      word_count <= word_count_next;
    end
  end

  // Output stage: a new result goes to the output register when it is free or
  // drains this cycle, otherwise to the skid register. Input stalls only while
  // the skid register is full.
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && emit;
        end
      end else if (accept && emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && emit) begin
        out_data <= emit_data;
      end
    end else if (accept && emit) begin
      skid_data <= emit_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, out_data};

  // The skid register is only ever occupied behind a waiting output.
  `PSD_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A result that is not taken stays on the output.
  `PSD_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !m_tready, out_valid)
  // A word marked tlast always returns the parser to scan at a record start.
  `PSD_ASSERT_NEXT(a_record_restart, clk, rst, accept && s_tlast,
                   (mode == MODE_SCAN) && at_record_start && (word_count == '0))
  // The word counter never passes the forced end of a record.
  `PSD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, word_count <= LAST_CNT)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for particle_slice_stream_decoder_core: random and directed
// probe records in, predicted particle statistics compared against every result transfer.
// Depends on psd_pkg (mode codes, register indexes, result layout) and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import psd_pkg::*;

  localparam int RECORD_LIMIT = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 8;

  localparam logic [15:0] TIMING_FLAG = 16'h8000;
  localparam logic [15:0] DATA_MASK   = 16'h3fff;
  localparam logic [15:0] NO_TIMING   = 16'h7fff;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } probe_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [8:0]        cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;    // [15:0] probe_word
  logic              s_tlast = 1'b0;  // record_last
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;         // [27:0] time_word ... [91] lower_flag, rest zero

  particle_slice_stream_decoder_core #(
    .RECORD_WORDS(RECORD_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores.
  probe_item_t probe_feed[$];
  logic [15:0] rec_buf[$];
  result_t     pending_particles[$];
  int          queued_count = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          feed_gap = 0;
  int          drain_wait = 0;
  int          hold_asked = 0;
  int          hold_seen = 0;
  bit          calm = 1'b0;
  probe_item_t next_item;
  result_t     due_result;
  result_t     seen_result;

  // Decoder shadow state, kept at the block's widths.
  mode_t       p_mode;
  bit          rec_start;
  bit          rec_skip;
  logic [15:0] held_w;
  bit          marker_pend;
  bit          slc_open;
  logic [8:0]  slc_shaded;
  logic [8:0]  slc_unshaded;
  logic [27:0] p_time;
  logic [10:0] cnt_width;
  logic [8:0]  cnt_height;
  logic [19:0] cnt_area;
  logic [10:0] cnt_upper;
  logic [10:0] cnt_lower;
  bit          flag_up;
  bit          flag_lo;
  int          rec_words;
  logic [7:0]  lim_upper;
  logic [8:0]  lim_lower;

  function automatic int clamp_add(input int a, input int b, input int top);
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Mostly back-to-back, some short pauses, a few long ones; none while calm.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic reset_particle();
    marker_pend  = 1'b0;
    slc_open     = 1'b0;
    slc_shaded   = '0;
    slc_unshaded = '0;
    cnt_width    = '0;
    cnt_height   = '0;
    cnt_area     = '0;
    cnt_upper    = '0;
    cnt_lower    = '0;
    flag_up      = 1'b0;
    flag_lo      = 1'b0;
  endtask

  // Fold the open slice into the particle totals.
  task automatic fold_slice();
    if (slc_open) begin
      if (slc_unshaded <= {1'b0, lim_upper}) begin
        cnt_upper = 11'(clamp_add(int'(cnt_upper), 1, 2047));
        flag_up = 1'b1;
      end
      if (int'(slc_shaded) + int'(slc_unshaded) >= int'(lim_lower)) begin
        cnt_lower = 11'(clamp_add(int'(cnt_lower), 1, 2047));
        flag_lo = 1'b1;
      end
      cnt_area = 20'(clamp_add(int'(cnt_area), int'(slc_shaded), 1048575));
      if (slc_shaded > cnt_height) cnt_height = slc_shaded;
      slc_open     = 1'b0;
      marker_pend  = 1'b0;
      slc_shaded   = '0;
      slc_unshaded = '0;
    end
  endtask

  task automatic capture_result();
    result_t r;
    r = '0;
    r.time_word     = p_time;
    r.width_slices  = cnt_width;
    r.height_max    = cnt_height;
    r.shaded_area   = cnt_area;
    r.upper_touches = cnt_upper;
    r.lower_touches = cnt_lower;
    r.upper_flag    = flag_up;
    r.lower_flag    = flag_lo;
    pending_particles.insert(pending_particles.size(), r);
  endtask

  // Advance the shadow decoder by one accepted probe word.
  task automatic decode_word(input logic [15:0] w, input logic lst);
    bit at_end;
    rec_words = (rec_words + 1) & 'h1ffff;
    at_end = lst || (rec_words >= RECORD_LIMIT);
    if (rec_start && w == SKIP_WORD) rec_skip = 1'b1;
    rec_start = 1'b0;
    if (!rec_skip) begin
      case (p_mode)
        MODE_HELD: begin
          if (w[15]) begin
            p_time = {held_w[13:0], w[13:0]};
            reset_particle();
            p_mode = MODE_PART;
          end else begin
            p_mode = MODE_SCAN;
          end
        end
        MODE_PART: begin
          if (marker_pend) begin
            // The word after a marker is slice data, whatever it looks like.
            marker_pend  = 1'b0;
            slc_shaded   = {2'b00, w[13:7]};
            slc_unshaded = MARKER_ADD + {2'b00, w[6:0]};
          end else if (w[15]) begin
            fold_slice();
            capture_result();
            held_w = w;
            p_mode = MODE_HELD;
          end else if (slc_open && w[15:14] == 2'b00) begin
            slc_shaded = 9'(clamp_add(int'(slc_shaded), int'(w[13:7]) + int'(w[6:0]), 511));
          end else begin
            fold_slice();
            cnt_width = 11'(clamp_add(int'(cnt_width), 1, 2047));
            slc_open = 1'b1;
            if (w == MARKER_WORD) begin
              marker_pend  = 1'b1;
              slc_shaded   = '0;
              slc_unshaded = MARKER_ADD;
            end else begin
              slc_shaded   = {2'b00, w[13:7]};
              slc_unshaded = {2'b00, w[6:0]};
            end
          end
        end
        default: begin
          if (w[15]) begin
            held_w = w;
            p_mode = MODE_HELD;
          end else begin
            p_mode = MODE_SCAN;
          end
        end
      endcase
    end
    if (at_end) begin
      if (!rec_skip && p_mode == MODE_PART) begin
        fold_slice();
        capture_result();
      end
      p_mode    = MODE_SCAN;
      reset_particle();
      rec_start = 1'b1;
      rec_skip  = 1'b0;
      rec_words = 0;
    end
  endtask

  task automatic enqueue(input logic [15:0] w, input logic lst);
    probe_item_t it;
    it.word = w;
    it.last = lst;
    probe_feed.insert(probe_feed.size(), it);
    queued_count++;
  endtask

  // Append one word to the record under construction.
  task automatic rec_add(input logic [15:0] w);
    rec_buf.insert(rec_buf.size(), w);
  endtask

  // One record: mostly well-formed particles with random content, some noise,
  // some ignored records.
  task automatic build_record();
    int kind;
    int n_part;
    int n_slice;
    int n_cont;
    int ending;
    rec_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      rec_add(SKIP_WORD);
      n_part = $urandom_range(1, 8);
      repeat (n_part) rec_add(TIMING_FLAG | rand_word());
    end else if (kind < 20) begin
      n_part = $urandom_range(1, 10);
      repeat (n_part) rec_add(rand_word());
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        // A lone timing word and the word it swallows.
        rec_add(TIMING_FLAG | rand_word());
        rec_add(rand_word() & NO_TIMING);
      end
      n_part = $urandom_range(1, 3);
      rec_add(TIMING_FLAG | rand_word());
      for (int p = 0; p < n_part; p++) begin
        rec_add(TIMING_FLAG | rand_word());
        n_slice = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        for (int s = 0; s < n_slice; s++) begin
          if ($urandom_range(0, 5) == 0) begin
            rec_add(MARKER_WORD);
            rec_add(($urandom_range(0, 7) == 0) ? MARKER_WORD : rand_word());
          end else if (s == 0 && $urandom_range(0, 3) == 0) begin
            rec_add(rand_word() & DATA_MASK);
          end else begin
            rec_add(MARKER_WORD | (rand_word() & DATA_MASK));
          end
          n_cont = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
          repeat (n_cont) rec_add(rand_word() & DATA_MASK);
        end
        // The closing word doubles as the first timing word of the next particle.
        if (p < n_part - 1) rec_add(TIMING_FLAG | rand_word());
      end
      ending = $urandom_range(0, 9);
      if (ending < 2) begin
        rec_add(TIMING_FLAG | rand_word());
      end else if (ending < 4) begin
        rec_add(TIMING_FLAG | rand_word());
        rec_add(rand_word() & NO_TIMING);
      end else if (ending == 4) begin
        rec_add(MARKER_WORD);
      end
    end
    for (int i = 0; i < rec_buf.size(); i++) enqueue(rec_buf[i], i == rec_buf.size() - 1);
  endtask

  task automatic fill_random(input int budget);
    int target;
    target = queued_count + budget;
    while (queued_count < target) build_record();
  endtask

  // Registers change only while the decoder is idle, so the shadow copy can follow at once.
  task automatic write_limit(input logic idx, input logic [8:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_UPPER_LIMIT) lim_upper = val[7:0];
    else lim_lower = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (probe_feed.size() != 0 || s_tvalid || pending_particles.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: each accepted transfer goes through the shadow decoder, then the next
  // word is offered after a random pause.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_word(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (feed_gap > 0) begin
          feed_gap = feed_gap - 1;
          s_tvalid <= 1'b0;
          s_tdata  <= rand_word();
          s_tlast  <= 1'($urandom_range(0, 1));
        end else if (probe_feed.size() != 0) begin
          next_item = probe_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.word;
          s_tlast  <= next_item.last;
          feed_gap = idle_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      drain_wait = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (drain_wait > 0) begin
      drain_wait = drain_wait - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      drain_wait = idle_gap();
    end
  end

  // Every result transfer is matched against the oldest predicted particle.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_particles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        due_result  = pending_particles.pop_front();
        seen_result = m_tdata[91:0];
        compare_field("time_word", 32'(due_result.time_word), 32'(seen_result.time_word));
        compare_field("width_slices", 32'(due_result.width_slices),
                      32'(seen_result.width_slices));
        compare_field("height_max", 32'(due_result.height_max), 32'(seen_result.height_max));
        compare_field("shaded_area", 32'(due_result.shaded_area),
                      32'(seen_result.shaded_area));
        compare_field("upper_touches", 32'(due_result.upper_touches),
                      32'(seen_result.upper_touches));
        compare_field("lower_touches", 32'(due_result.lower_touches),
                      32'(seen_result.lower_touches));
        compare_field("upper_flag", 32'(due_result.upper_flag), 32'(seen_result.upper_flag));
        compare_field("lower_flag", 32'(due_result.lower_flag), 32'(seen_result.lower_flag));
        compare_field("padding", 32'd0, 32'(m_tdata[OUT_W-1:92]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("particle_slice_stream_decoder_core regression: fail");
      $finish;
    end
  end

  initial begin
    p_mode    = MODE_SCAN;
    rec_start = 1'b1;
    rec_skip  = 1'b0;
    held_w    = '0;
    p_time    = '0;
    rec_words = 0;
    lim_upper = UPPER_RESET;
    lim_lower = LOWER_RESET;
    reset_particle();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ignored record: nothing may come out of it.
    enqueue(SKIP_WORD, 1'b0);
    enqueue(16'h8001, 1'b0);
    enqueue(16'h8002, 1'b0);
    enqueue(16'h4123, 1'b1);
    // Lone timing word, then the widest time word, a saturating slice, a closing
    // word reused as timing, a marker followed by a bit-15 word and a trailing marker.
    enqueue(16'h8005, 1'b0);
    enqueue(16'h1234, 1'b0);
    enqueue(16'hffff, 1'b0);
    enqueue(16'hbfff, 1'b0);
    enqueue(16'h7fff, 1'b0);
    enqueue(16'h3fff, 1'b0);
    enqueue(16'h3fff, 1'b0);
    enqueue(16'h8000, 1'b0);
    enqueue(16'h8000, 1'b0);
    enqueue(16'h0000, 1'b0);
    enqueue(MARKER_WORD, 1'b0);
    enqueue(16'hc000, 1'b0);
    enqueue(MARKER_WORD, 1'b1);
    // Empty particle closed by a timing word that is then dropped at record end.
    enqueue(16'h8abc, 1'b0);
    enqueue(16'h8def, 1'b0);
    enqueue(16'h8123, 1'b1);
    // A marker taken as the data word of the marker before it.
    enqueue(16'h8001, 1'b0);
    enqueue(16'h8002, 1'b0);
    enqueue(MARKER_WORD, 1'b0);
    enqueue(MARKER_WORD, 1'b0);
    enqueue(16'h0055, 1'b1);
    fill_random(80);
    drain();

    // Widest limits; bit 8 of the upper write must be dropped.
    write_limit(REG_UPPER_LIMIT, 9'h1ff);
    write_limit(REG_LOWER_LIMIT, 9'd511);
    calm <= 1'b1;
    @(negedge clk);
    fill_random(80);
    drain();

    // Narrowest limits, with a long receiver hold-off so the output fills up.
    write_limit(REG_UPPER_LIMIT, 9'd0);
    write_limit(REG_LOWER_LIMIT, 9'd0);
    calm <= 1'b0;
    @(negedge clk);
    fill_random(80);
    hold_asked <= hold_asked + 1;
    drain();

    write_limit(REG_UPPER_LIMIT, 9'($urandom_range(0, 511)));
    write_limit(REG_LOWER_LIMIT, 9'($urandom_range(0, 511)));
    @(negedge clk);
    fill_random(80);
    drain();

    // A record with no end mark, cut off by its word count, then normal records.
    write_limit(REG_UPPER_LIMIT, 9'($urandom_range(0, 255)));
    write_limit(REG_LOWER_LIMIT, 9'($urandom_range(0, 511)));
    calm <= 1'b1;
    @(negedge clk);
    enqueue(TIMING_FLAG | rand_word(), 1'b0);
    enqueue(TIMING_FLAG | rand_word(), 1'b0);
    for (int i = 0; i < RECORD_LIMIT - 2; i++) begin
      enqueue((i % 3 == 0) ? (MARKER_WORD | (rand_word() & DATA_MASK))
                           : (rand_word() & DATA_MASK), 1'b0);
    end
    fill_random(40);
    drain();

    if (mismatches == 0 && pending_particles.size() == 0) begin
      $display("particle_slice_stream_decoder_core regression: pass");
    end else begin
      $display("particle_slice_stream_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
